// ----- hdl/slhs_pkg.sv -----
// Shared types, constants and codes of the store/load hazard scan.
// No dependencies; every other file imports this package.
`default_nettype none

package slhs_pkg;

    localparam int KEY_TABLE_DEPTH = 32;
    localparam int KEY_W           = 41;
    localparam int CNT_W           = $clog2(KEY_TABLE_DEPTH + 1);
    localparam int IDX_W           = (KEY_TABLE_DEPTH > 1) ? $clog2(KEY_TABLE_DEPTH) : 1;
    localparam int KEPT_W          = 6;
    localparam int KEPT_MAX        = 63;

    localparam int QUEUE_DEPTH     = 2;
    localparam int QPTR_W          = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
    localparam int QCNT_W          = $clog2(QUEUE_DEPTH + 1);

    localparam logic [31:0] IMM12_MASK  = 32'h3B00_0000;
    localparam logic [31:0] IMM12_MATCH = 32'h3900_0000;
    localparam logic [31:0] IMM9_MASK   = 32'h3B20_0C00;
    localparam logic [31:0] IMM9_MATCH  = 32'h3800_0000;
    localparam logic [1:0]  OPC_STORE   = 2'd0;

    typedef struct packed {
        logic [31:0] instr_word;
        logic        word_present;
        logic        last_word;
    } scan_word_t;

    typedef struct packed {
        logic              hazard_found;
        logic [KEPT_W-1:0] stores_kept;
    } scan_rpt_t;

    typedef enum logic [1:0] {
        OP_NONE,
        OP_STORE,
        OP_LOAD
    } op_kind_t;

    typedef struct packed {
        op_kind_t         kind;
        logic [KEY_W-1:0] key;
        logic             last;
    } scan_op_t;

    typedef enum logic {
        BK_IDLE,
        BK_CMP
    } back_state_t;

endpackage

`default_nettype wire

// ----- hdl/slhs_front.sv -----
// Front end: takes scan words, decodes load/store forms into keys.
// Depends on slhs_pkg; feeds slhs_queue.
`default_nettype none

module slhs_front
    import slhs_pkg::*;
(
    input  wire logic       scan_valid,
    output logic            scan_stall,
    input  wire scan_word_t scan_word,
    input  wire logic       q_full,
    output logic            push,
    output scan_op_t        push_op
);

    logic [31:0] w;
    logic        is_imm12;
    logic        is_imm9;

    assign w          = scan_word.instr_word;
    assign scan_stall = q_full;
    assign push       = scan_valid && !q_full;

    assign is_imm12 = (w & IMM12_MASK) == IMM12_MATCH;
    assign is_imm9  = (w & IMM9_MASK) == IMM9_MATCH;

    always_comb
    begin
        push_op.last = scan_word.last_word;
        push_op.key  = '0;
        push_op.kind = OP_NONE;
        if (scan_word.word_present && (is_imm12 || is_imm9))
        begin
            push_op.kind      = (w[23:22] == OPC_STORE) ? OP_STORE : OP_LOAD;
            push_op.key[25:24] = w[31:30];
            push_op.key[16:12] = w[9:5];
            if (is_imm12)
            begin
                push_op.key[11:0] = w[21:10];
            end
            else
            begin
                push_op.key[40]  = 1'b1;
                push_op.key[8:0] = w[20:12];
            end
        end
    end

endmodule

`default_nettype wire

// ----- hdl/slhs_queue.sv -----
// Short FIFO of decoded ops between front and back ends.
// Depends on slhs_pkg.
`default_nettype none

module slhs_queue
    import slhs_pkg::*;
(
    input  wire logic     clk,
    input  wire logic     rst_n,
    input  wire logic     push,
    input  wire scan_op_t push_op,
    output logic          full,
    input  wire logic     pop,
    output logic          head_valid,
    output scan_op_t      head_op
);

    scan_op_t           mem_reg [QUEUE_DEPTH];
    logic [QPTR_W-1:0]  wr_ptr_reg, wr_ptr_next;
    logic [QPTR_W-1:0]  rd_ptr_reg, rd_ptr_next;
    logic [QCNT_W-1:0]  cnt_reg, cnt_next;

    function automatic logic [QPTR_W-1:0] ptr_inc(input logic [QPTR_W-1:0] p);
        return (p == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : p + 1'b1;
    endfunction

    assign full       = cnt_reg == QCNT_W'(QUEUE_DEPTH);
    assign head_valid = cnt_reg != '0;
    assign head_op    = mem_reg[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = push ? ptr_inc(wr_ptr_reg) : wr_ptr_reg;
        rd_ptr_next = pop ? ptr_inc(rd_ptr_reg) : rd_ptr_reg;
        cnt_next    = cnt_reg + QCNT_W'(push) - QCNT_W'(pop);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            cnt_reg    <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            cnt_reg    <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            mem_reg[wr_ptr_reg] <= push_op;
        end
    end

endmodule

`default_nettype wire

// ----- hdl/slhs_back.sv -----
// Back end: store key table, load compare, sticky hazard and report register.
// Depends on slhs_pkg; drains slhs_queue.
`default_nettype none

module slhs_back
    import slhs_pkg::*;
(
    input  wire logic     clk,
    input  wire logic     rst_n,
    input  wire logic     head_valid,
    input  wire scan_op_t head_op,
    output logic          pop,
    output logic          rpt_valid,
    input  wire logic     rpt_stall,
    output scan_rpt_t     rpt
);

    logic [KEY_W-1:0]           keys_mem [KEY_TABLE_DEPTH];
    back_state_t                state_reg, state_next;
    logic [CNT_W-1:0]           count_reg, count_next;
    logic                       sticky_reg, sticky_next;
    logic [KEY_TABLE_DEPTH-1:0] match_reg, match_next;
    logic                       last_reg, last_next;
    logic                       out_valid_reg, out_valid_next;
    scan_rpt_t                  out_reg, out_next;

    logic [KEY_TABLE_DEPTH-1:0] match_now;
    logic                       out_free;
    logic                       active;
    logic                       wr_en;
    logic                       emit;
    logic                       hz_cmp;

    function automatic logic [KEPT_W-1:0] sat_kept(input logic [CNT_W-1:0] c);
        logic [CNT_W+KEPT_W-1:0] wide;
        wide = (CNT_W + KEPT_W)'(c);
        if (wide > (CNT_W + KEPT_W)'(KEPT_MAX))
        begin
            return KEPT_W'(KEPT_MAX);
        end
        return wide[KEPT_W-1:0];
    endfunction

    always_comb
    begin
        for (int i = 0; i < KEY_TABLE_DEPTH; i++)
        begin
            match_now[i] = (CNT_W'(i) < count_reg) && (keys_mem[i] == head_op.key);
        end
    end

    assign out_free  = !out_valid_reg || !rpt_stall;
    assign active    = !sticky_reg;
    assign hz_cmp    = sticky_reg || (|match_reg);
    assign rpt_valid = out_valid_reg;
    assign rpt       = out_reg;

    // next state
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            BK_IDLE:
            begin
                if (head_valid && active && head_op.kind == OP_LOAD)
                begin
                    state_next = BK_CMP;
                end
            end
            BK_CMP:
            begin
                if (!last_reg || out_free)
                begin
                    state_next = BK_IDLE;
                end
            end
            default: state_next = BK_IDLE;
        endcase
    end

    // datapath controls
    always_comb
    begin
        pop         = 1'b0;
        wr_en       = 1'b0;
        emit        = 1'b0;
        count_next  = count_reg;
        sticky_next = sticky_reg;
        match_next  = match_reg;
        last_next   = last_reg;
        out_next    = out_reg;
        unique case (state_reg)
            BK_IDLE:
            begin
                if (head_valid)
                begin
                    if (active && head_op.kind == OP_LOAD)
                    begin
                        pop        = 1'b1;
                        match_next = match_now;
                        last_next  = head_op.last;
                    end
                    else if (!head_op.last || out_free)
                    begin
                        pop = 1'b1;
                        if (active && head_op.kind == OP_STORE &&
                            count_reg < CNT_W'(KEY_TABLE_DEPTH))
                        begin
                            wr_en      = 1'b1;
                            count_next = count_reg + 1'b1;
                        end
                        if (head_op.last)
                        begin
                            emit                 = 1'b1;
                            out_next.hazard_found = sticky_reg;
                            out_next.stores_kept  = sat_kept(count_next);
                            count_next           = '0;
                            sticky_next          = 1'b0;
                        end
                    end
                end
            end
            BK_CMP:
            begin
                if (!last_reg)
                begin
                    sticky_next = hz_cmp;
                end
                else if (out_free)
                begin
                    emit                 = 1'b1;
                    out_next.hazard_found = hz_cmp;
                    out_next.stores_kept  = sat_kept(count_reg);
                    count_next           = '0;
                    sticky_next          = 1'b0;
                end
            end
            default: ;
        endcase
        if (emit)
        begin
            out_valid_next = 1'b1;
        end
        else if (!rpt_stall)
        begin
            out_valid_next = 1'b0;
        end
        else
        begin
            out_valid_next = out_valid_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= BK_IDLE;
            count_reg     <= '0;
            sticky_reg    <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            count_reg     <= count_next;
            sticky_reg    <= sticky_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        match_reg <= match_next;
        last_reg  <= last_next;
        out_reg   <= out_next;
        if (wr_en)
        begin
            keys_mem[count_reg[IDX_W-1:0]] <= head_op.key;
        end
    end

endmodule

`default_nettype wire

// ----- hdl/store_load_same_address_hazard_scan_top.sv -----
// Top level of the store/load same-address hazard scan.
// Depends on slhs_pkg, slhs_front, slhs_queue, slhs_back.
//
//   channel | valid       | stall       | word
//   scan    | scan_valid  | scan_stall  | scan_word (scan_word_t)
//   rpt     | rpt_valid   | rpt_stall   | rpt       (scan_rpt_t)
//
// Stores, unrecognized words, markers and words after a hazard are handled in BK_IDLE alone;
// loads of an unflagged run compare against the kept entries and register the matches in
// BK_IDLE, then reduce them in BK_CMP. Each report is registered in out_reg.
// A two-entry queue decouples the front; scan_stall rises when it is full.
// Reset clears queue, count, hazard flag and report valid; table needs none.
`default_nettype none

module store_load_same_address_hazard_scan_top
    import slhs_pkg::*;
(
    input  wire logic       clk,
    input  wire logic       rst_n,
    input  wire logic       scan_valid,
    output logic            scan_stall,
    input  wire scan_word_t scan_word,
    output logic            rpt_valid,
    input  wire logic       rpt_stall,
    output scan_rpt_t       rpt
);

    logic     q_full;
    logic     push;
    scan_op_t push_op;
    logic     pop;
    logic     head_valid;
    scan_op_t head_op;

    slhs_front u_front (
        .scan_valid (scan_valid),
        .scan_stall (scan_stall),
        .scan_word  (scan_word),
        .q_full     (q_full),
        .push       (push),
        .push_op    (push_op)
    );

    slhs_queue u_queue (
        .clk        (clk),
        .rst_n      (rst_n),
        .push       (push),
        .push_op    (push_op),
        .full       (q_full),
        .pop        (pop),
        .head_valid (head_valid),
        .head_op    (head_op)
    );

    slhs_back u_back (
        .clk        (clk),
        .rst_n      (rst_n),
        .head_valid (head_valid),
        .head_op    (head_op),
        .pop        (pop),
        .rpt_valid  (rpt_valid),
        .rpt_stall  (rpt_stall),
        .rpt        (rpt)
    );

endmodule

`default_nettype wire

// ----- hdl/slhs_checker.sv -----
// Port-level checks of the hazard scan top, bound to it below.
// Depends on slhs_pkg and store_load_same_address_hazard_scan_top.
`default_nettype none

module slhs_checker
    import slhs_pkg::*;
(
    input wire logic       clk,
    input wire logic       rst_n,
    input wire logic       scan_valid,
    input wire logic       scan_stall,
    input wire scan_word_t scan_word,
    input wire logic       rpt_valid,
    input wire logic       rpt_stall,
    input wire scan_rpt_t  rpt
);

    a_scan_hold: assert property (@(posedge clk) disable iff (!rst_n)
        scan_valid && scan_stall |=> scan_valid && $stable(scan_word))
        else $error("scan word changed while stalled");

    a_rpt_hold: assert property (@(posedge clk) disable iff (!rst_n)
        rpt_valid && rpt_stall |=> rpt_valid && $stable(rpt))
        else $error("report changed while stalled");

    a_kept_range: assert property (@(posedge clk) disable iff (!rst_n)
        rpt_valid |-> rpt.stores_kept <= KEPT_W'(KEY_TABLE_DEPTH))
        else $error("stores_kept beyond table depth");

    a_hazard_needs_store: assert property (@(posedge clk) disable iff (!rst_n)
        rpt_valid && rpt.hazard_found |-> rpt.stores_kept != '0)
        else $error("hazard without any kept store");

    a_reset_quiet: assert property (@(posedge clk)
        $rose(rst_n) |-> !rpt_valid)
        else $error("report valid out of reset");

endmodule

bind store_load_same_address_hazard_scan_top slhs_checker u_slhs_checker (.*);

`default_nettype wire
